[rtl/ardv_pkg.sv]
package ardv_pkg;

    // Field and register widths.
    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int MASTER_W    = 6;
    localparam int CHAN_W      = 5;
    localparam int GAIN_W      = 17;
    localparam int COMB_GAIN_W = 33;
    localparam int PROD_W      = GAIN_W + COMB_GAIN_W;
    localparam int SCALE_SHIFT = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP   = 3'd5;

    // Register reset values.
    localparam logic [MASTER_W-1:0] MASTER_RST = 6'd40;
    localparam logic [CHAN_W-1:0]   CHAN_RST   = 5'd20;
    localparam logic [CFG_W-1:0]    PRIME_RST  = 15'd1000;
    localparam logic [CFG_W-1:0]    SKIP_RST   = 15'd8000;
    localparam logic [CFG_W-1:0]    KEEP_RST   = 15'd2000;

    // Attenuation step counts; a level at or above these is unity gain.
    localparam logic [MASTER_W-1:0] MASTER_STEPS = 6'd40;
    localparam logic [CHAN_W-1:0]   CHAN_STEPS   = 5'd20;
    localparam logic [GAIN_W-1:0]   GAIN_UNITY   = 17'd65536;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic                   en;
        logic [GAIN_W-1:0]      op_a;
        logic [COMB_GAIN_W-1:0] op_b;
    } mul_req_t;

    // Gain of -2*step dB in unsigned Q1.16.
    function automatic logic [GAIN_W-1:0] gain_rom(input logic [MASTER_W-1:0] step);
        logic [GAIN_W-1:0] g;
        unique case (step)
            6'd0:  g = 17'd65536;
            6'd1:  g = 17'd52058;
            6'd2:  g = 17'd41350;
            6'd3:  g = 17'd32846;
            6'd4:  g = 17'd26090;
            6'd5:  g = 17'd20724;
            6'd6:  g = 17'd16462;
            6'd7:  g = 17'd13076;
            6'd8:  g = 17'd10387;
            6'd9:  g = 17'd8250;
            6'd10: g = 17'd6554;
            6'd11: g = 17'd5206;
            6'd12: g = 17'd4135;
            6'd13: g = 17'd3285;
            6'd14: g = 17'd2609;
            6'd15: g = 17'd2072;
            6'd16: g = 17'd1646;
            6'd17: g = 17'd1308;
            6'd18: g = 17'd1039;
            6'd19: g = 17'd825;
            6'd20: g = 17'd655;
            6'd21: g = 17'd521;
            6'd22: g = 17'd414;
            6'd23: g = 17'd328;
            6'd24: g = 17'd261;
            6'd25: g = 17'd207;
            6'd26: g = 17'd165;
            6'd27: g = 17'd131;
            6'd28: g = 17'd104;
            6'd29: g = 17'd83;
            6'd30: g = 17'd66;
            6'd31: g = 17'd52;
            6'd32: g = 17'd41;
            6'd33: g = 17'd33;
            6'd34: g = 17'd26;
            6'd35: g = 17'd21;
            6'd36: g = 17'd16;
            6'd37: g = 17'd13;
            6'd38: g = 17'd10;
            6'd39: g = 17'd8;
            6'd40: g = 17'd7;
            default: g = '0;
        endcase
        return g;
    endfunction

    // Master gain from its level register.
    function automatic logic [GAIN_W-1:0] master_gain(input logic [MASTER_W-1:0] level);
        logic [GAIN_W-1:0] g;
        if (level < MASTER_STEPS) begin
            g = gain_rom(MASTER_STEPS - level);
        end else begin
            g = GAIN_UNITY;
        end
        return g;
    endfunction

    // Channel gain from its level register.
    function automatic logic [GAIN_W-1:0] chan_gain(input logic [CHAN_W-1:0] level);
        logic [GAIN_W-1:0] g;
        if (level < CHAN_STEPS) begin
            g = gain_rom(MASTER_W'(CHAN_STEPS - level));
        end else begin
            g = GAIN_UNITY;
        end
        return g;
    endfunction

endpackage

[rtl/audio_ring_drain_with_volume.sv]
// Stereo sample ring with dB volume. A push word stores one 16-bit left/right
// frame in an on-chip ring of RING_FRAMES entries, or is refused when the ring
// is full; a pull word returns one frame, scaled by master times channel gain
// and truncated toward zero, or silence while the ring is not primed or empty.
// A pull with batch_start set first re-checks the fill against prime_frames and
// skip_frames and may jump the reader so that keep_frames frames remain. One
// word is in flight at a time. A push passes the capture, policy and done
// steps; a pull passes capture, policy, a skip step after a batch check,
// read, then for a popped frame gain, left and right multiply, and done.
// The result is presented as the block becomes ready for the next word, and
// a result still waiting in the output register holds the sequencer in its
// final step until the receiver takes it. The sequencer drives a single
// shared 17x33 multiplier that forms the left and right combined gains and
// then scales left and right in turn, behind one registered read of the ring
// memory. The result register lets the next word be accepted while a result
// waits. Configuration may only be written while no word is in flight. No
// clearing pass is needed after reset.
module audio_ring_drain_with_volume
    import ardv_pkg::*;
#(
    parameter int RING_FRAMES = 16384
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic                 s_batch_start,
    input  logic signed [15:0]   s_in_left,
    input  logic signed [15:0]   s_in_right,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_out_left,
    output logic signed [15:0]   m_out_right,
    output logic                 m_popped,
    output logic                 m_push_refused,
    output logic                 m_is_primed
);

    localparam int PW = $clog2(2 * RING_FRAMES);
    localparam int IW = $clog2(RING_FRAMES);
    localparam int CW = (PW > CFG_W) ? PW : CFG_W;
    localparam logic [PW:0]   PTR_MOD  = (PW + 1)'(2 * RING_FRAMES);
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * RING_FRAMES - 1);
    localparam logic [PW-1:0] RING_LEN = PW'(RING_FRAMES);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_POLICY = 3'd1;
    localparam logic [2:0] ST_SKIP   = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_GAIN   = 3'd4;
    localparam logic [2:0] ST_MUL_L  = 3'd5;
    localparam logic [2:0] ST_MUL_R  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    // Configuration registers.
    logic [MASTER_W-1:0] master_reg;
    logic [CHAN_W-1:0]   left_lvl_reg;
    logic [CHAN_W-1:0]   right_lvl_reg;
    logic [CFG_W-1:0]    prime_reg;
    logic [CFG_W-1:0]    skip_cfg_reg;
    logic [CFG_W-1:0]    keep_cfg_reg;

    // Ring control state.
    logic [2:0]    state_reg;
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [PW-1:0] fill_reg;
    logic          primed_reg;
    logic          skip_reg;
    logic [PW-1:0] keep_reg;

    // Captured word and working values.
    logic                   op_reg;
    logic                   batch_reg;
    sample_t                in_left_reg;
    sample_t                in_right_reg;
    logic [2*SAMPLE_W-1:0]  mem_rdata_reg;
    logic [COMB_GAIN_W-1:0] gain_reg;
    logic [COMB_GAIN_W-1:0] gain_right_reg;
    sample_t                res_left_reg;
    logic                   popped_reg;
    logic                   refused_reg;

    // Result register.
    logic    m_valid_reg;
    sample_t out_left_reg;
    sample_t out_right_reg;
    logic    out_popped_reg;
    logic    out_refused_reg;
    logic    out_primed_reg;

    logic [2*SAMPLE_W-1:0] ring_mem [RING_FRAMES];

    mul_req_t          mul_req;
    logic [PROD_W-1:0] prod;

    logic          ring_full;
    logic          pop_ok;
    logic          out_free;
    logic [CW-1:0] fill_x;
    logic          primed_new;
    logic          do_skip;
    logic [PW-1:0] keep_min;
    logic [PW:0]   skip_diff;
    logic [PW-1:0] skip_ptr;
    logic [PW-1:0] wptr_inc;
    logic [PW-1:0] rptr_inc;
    logic [IW-1:0] widx;
    logic [IW-1:0] ridx;
    logic          mem_we;
    logic          mem_re;
    sample_t       raw_left;
    sample_t       raw_right;
    logic [GAIN_W-1:0] mag_left;
    logic [GAIN_W-1:0] mag_right;

    // Restore the sign of a truncated magnitude.
    function automatic sample_t apply_sign(input logic neg, input sample_t mag);
        sample_t r;
        r = neg ? sample_t'(~mag + 16'd1) : mag;
        return r;
    endfunction

    // Magnitude of a raw sample, 32768 for the most negative code.
    function automatic logic [GAIN_W-1:0] sample_mag(input sample_t raw);
        logic [GAIN_W-1:0] m;
        m = raw[SAMPLE_W-1] ? (GAIN_W'(17'h10000) - {1'b0, raw}) : {1'b0, raw};
        return m;
    endfunction

    // Fill and policy decisions.
    assign ring_full  = (fill_reg == RING_LEN);
    assign pop_ok     = primed_reg && (fill_reg != '0);
    assign out_free   = !m_valid_reg || m_ready;
    assign fill_x     = CW'(fill_reg);
    assign primed_new = (fill_reg != '0) && (primed_reg || (fill_x >= CW'(prime_reg)));
    assign do_skip    = primed_new && (fill_x > CW'(skip_cfg_reg));
    assign keep_min   = (CW'(keep_cfg_reg) < fill_x) ? PW'(keep_cfg_reg) : fill_reg;

    // Pointer arithmetic modulo twice the ring length.
    assign skip_diff = {1'b0, wptr_reg} - {1'b0, keep_reg};
    assign skip_ptr  = skip_diff[PW] ? PW'(skip_diff + PTR_MOD) : skip_diff[PW-1:0];
    assign wptr_inc  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
    assign rptr_inc  = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
    assign widx = (wptr_reg >= RING_LEN) ? IW'(wptr_reg - RING_LEN) : IW'(wptr_reg);
    assign ridx = (rptr_reg >= RING_LEN) ? IW'(rptr_reg - RING_LEN) : IW'(rptr_reg);

    assign mem_we = (state_reg == ST_POLICY) && !op_reg && !ring_full;
    assign mem_re = (state_reg == ST_READ) && pop_ok;

    assign raw_left  = mem_rdata_reg[2*SAMPLE_W-1:SAMPLE_W];
    assign raw_right = mem_rdata_reg[SAMPLE_W-1:0];
    assign mag_left  = sample_mag(raw_left);
    assign mag_right = sample_mag(raw_right);

    // Ring memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[widx] <= {in_left_reg, in_right_reg};
        end
        if (mem_re) begin
            mem_rdata_reg <= ring_mem[ridx];
        end
    end

    // Operand selection for the shared multiplier. The left combined gain is
    // formed in the read step, the right one in the gain step, and each
    // channel is then scaled by its own combined gain.
    always_comb begin
        mul_req = '0;
        case (state_reg)
            ST_READ: begin
                mul_req.en   = pop_ok;
                mul_req.op_a = master_gain(master_reg);
                mul_req.op_b = COMB_GAIN_W'(chan_gain(left_lvl_reg));
            end
            ST_GAIN: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = master_gain(master_reg);
                mul_req.op_b = COMB_GAIN_W'(chan_gain(right_lvl_reg));
            end
            ST_MUL_L: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = mag_left;
                mul_req.op_b = gain_reg;
            end
            ST_MUL_R: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = mag_right;
                mul_req.op_b = gain_right_reg;
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    ardv_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    // Sequencer, pointers and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            wptr_reg        <= '0;
            rptr_reg        <= '0;
            fill_reg        <= '0;
            primed_reg      <= 1'b0;
            skip_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            master_reg      <= MASTER_RST;
            left_lvl_reg    <= CHAN_RST;
            right_lvl_reg   <= CHAN_RST;
            prime_reg       <= PRIME_RST;
            skip_cfg_reg    <= SKIP_RST;
            keep_cfg_reg    <= KEEP_RST;
        end else begin
            // Configuration writes.
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MASTER: master_reg    <= cfg_wdata[MASTER_W-1:0];
                    CFG_LEFT:   left_lvl_reg  <= cfg_wdata[CHAN_W-1:0];
                    CFG_RIGHT:  right_lvl_reg <= cfg_wdata[CHAN_W-1:0];
                    CFG_PRIME:  prime_reg     <= cfg_wdata;
                    CFG_SKIP:   skip_cfg_reg  <= cfg_wdata;
                    CFG_KEEP:   keep_cfg_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // A taken result empties the output register unless the final
            // step refills it in the same cycle.
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg       <= s_opcode;
                        batch_reg    <= s_batch_start;
                        in_left_reg  <= s_in_left;
                        in_right_reg <= s_in_right;
                        state_reg    <= ST_POLICY;
                    end
                end
                ST_POLICY: begin
                    if (!op_reg) begin
                        // Push: store unless full.
                        res_left_reg <= '0;
                        popped_reg   <= 1'b0;
                        refused_reg  <= ring_full;
                        if (!ring_full) begin
                            wptr_reg <= wptr_inc;
                            fill_reg <= fill_reg + 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end else if (batch_reg) begin
                        primed_reg <= primed_new;
                        skip_reg   <= do_skip;
                        keep_reg   <= keep_min;
                        state_reg  <= ST_SKIP;
                    end else begin
                        state_reg <= ST_READ;
                    end
                end
                ST_SKIP: begin
                    if (skip_reg) begin
                        rptr_reg <= skip_ptr;
                        fill_reg <= keep_reg;
                    end
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    refused_reg <= 1'b0;
                    if (pop_ok) begin
                        rptr_reg   <= rptr_inc;
                        fill_reg   <= fill_reg - 1'b1;
                        popped_reg <= 1'b1;
                        state_reg  <= ST_GAIN;
                    end else begin
                        res_left_reg <= '0;
                        popped_reg   <= 1'b0;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_GAIN: begin
                    gain_reg  <= prod[COMB_GAIN_W-1:0];
                    state_reg <= ST_MUL_L;
                end
                ST_MUL_L: begin
                    gain_right_reg <= prod[COMB_GAIN_W-1:0];
                    state_reg      <= ST_MUL_R;
                end
                ST_MUL_R: begin
                    res_left_reg <= apply_sign(raw_left[SAMPLE_W-1],
                                               prod[SCALE_SHIFT +: SAMPLE_W]);
                    state_reg    <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        out_left_reg    <= res_left_reg;
                        out_right_reg   <= popped_reg ?
                            apply_sign(raw_right[SAMPLE_W-1], prod[SCALE_SHIFT +: SAMPLE_W]) :
                            '0;
                        out_popped_reg  <= popped_reg;
                        out_refused_reg <= refused_reg;
                        out_primed_reg  <= primed_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = aresetn && (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_out_left     = out_left_reg;
    assign m_out_right    = out_right_reg;
    assign m_popped       = out_popped_reg;
    assign m_push_refused = out_refused_reg;
    assign m_is_primed    = out_primed_reg;

`ifndef SYNTH
    // The fill never exceeds the ring length.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= RING_LEN)
        else $error("ring fill above ring length");

    // A popped frame is only ever reported while primed.
    a_pop_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_popped) |-> m_is_primed)
        else $error("frame popped while not primed");

    // A result is never both a pop and a refused push.
    a_pop_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_popped && m_push_refused))
        else $error("pop and refusal in one word");

    // A stored push grows the fill by exactly one.
    a_push_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POLICY && !op_reg && !ring_full)
        |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("push did not advance the fill");
`endif

endmodule

[rtl/ardv_mul.sv]
module ardv_mul
    import ardv_pkg::*;
(
    input  logic              aclk,
    input  mul_req_t          req,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    // Shared unsigned multiplier with a registered product.
    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= PROD_W'(req.op_a) * PROD_W'(req.op_b);
        end
    end

    assign prod = prod_reg;

endmodule
